// File: rtl/core/bounded_ordered_list_engine_macros.svh
// Assertion macros used by the list engine controller.
`ifndef BOUNDED_ORDERED_LIST_ENGINE_MACROS_SVH
`define BOUNDED_ORDERED_LIST_ENGINE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BOLE_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BOLE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/bole_pkg.sv
// Shared codes and command/status types of the ordered list engine.
package bole_pkg;

    localparam logic [3:0] A_INS_FRONT = 4'd0;
    localparam logic [3:0] A_INS_BACK  = 4'd1;
    localparam logic [3:0] A_INS_AT    = 4'd2;
    localparam logic [3:0] A_DEL_VAL   = 4'd3;
    localparam logic [3:0] A_DEL_FIRST = 4'd4;
    localparam logic [3:0] A_DEL_LAST  = 4'd5;
    localparam logic [3:0] A_CLEAR     = 4'd6;
    localparam logic [3:0] A_SEARCH    = 4'd7;
    localparam logic [3:0] A_SORT_UP   = 4'd8;
    localparam logic [3:0] A_SORT_DOWN = 4'd9;
    localparam logic [3:0] A_READ      = 4'd10;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_EMPTY    = 3'd1;
    localparam logic [2:0] ST_NOTFOUND = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_RANGE    = 3'd4;

    // Datapath micro-operations.
    localparam logic [4:0] U_NOP       = 5'd0;
    localparam logic [4:0] U_LOAD      = 5'd1;
    localparam logic [4:0] U_FIN       = 5'd2;
    localparam logic [4:0] U_FIN_FOUND = 5'd3;
    localparam logic [4:0] U_FIN_READ  = 5'd4;
    localparam logic [4:0] U_FIN_DEC   = 5'd5;
    localparam logic [4:0] U_FIN_CLR   = 5'd6;
    localparam logic [4:0] U_INS_INIT  = 5'd7;
    localparam logic [4:0] U_SHIFT_RD  = 5'd8;
    localparam logic [4:0] U_SHIFT_WR  = 5'd9;
    localparam logic [4:0] U_INS_FIN   = 5'd10;
    localparam logic [4:0] U_J_ZERO    = 5'd11;
    localparam logic [4:0] U_SCAN_RD   = 5'd12;
    localparam logic [4:0] U_J_INC     = 5'd13;
    localparam logic [4:0] U_RM_RD     = 5'd14;
    localparam logic [4:0] U_RM_WR     = 5'd15;
    localparam logic [4:0] U_I_ZERO    = 5'd16;
    localparam logic [4:0] U_SO_RDI    = 5'd17;
    localparam logic [4:0] U_SO_LDI    = 5'd18;
    localparam logic [4:0] U_SO_RDJ    = 5'd19;
    localparam logic [4:0] U_SO_CMP    = 5'd20;
    localparam logic [4:0] U_SO_SW1    = 5'd21;
    localparam logic [4:0] U_SO_SW2    = 5'd22;
    localparam logic [4:0] U_I_INC     = 5'd23;
    localparam logic [4:0] U_RD_POS    = 5'd24;

    typedef struct packed {
        logic [4:0] uop;
        logic [2:0] status;
    } t_cmd;

    typedef struct packed {
        logic [3:0] act;
        logic       empty;
        logic       full;
        logic       j_eq_i;
        logic       j_eq_cnt;
        logic       j1_ge_cnt;
        logic       i_eq_cnt;
        logic       match;
        logic       pick_ne_i;
        logic       pos_ge_cnt;
    } t_stat;

endpackage

// File: rtl/core/bole_dpath.sv
// Datapath of the ordered list engine: entry memory, count, indexes, results.
module bole_dpath import bole_pkg::*; #(
    parameter int CAPACITY = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    input  logic [3:0]         i_action,
    input  logic signed [31:0] i_value,
    input  logic [6:0]         i_position,
    output t_stat              o_stat,
    output logic [2:0]         o_status,
    output logic               o_found,
    output logic signed [31:0] o_read_value,
    output logic [6:0]         o_entry_count
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = (CW > 7) ? CW : 7;

    logic signed [31:0] mem [CAPACITY];
    logic signed [31:0] r_rd;

    logic [CW-1:0]      r_cnt;
    logic [CW-1:0]      r_j;
    logic [CW-1:0]      r_i;
    logic [CW-1:0]      r_pick;
    logic signed [31:0] r_pick_val;
    logic signed [31:0] r_cur_val;
    logic [3:0]         r_act;
    logic signed [31:0] r_val;
    logic [6:0]         r_pos;
    logic [2:0]         r_status;
    logic               r_found;
    logic signed [31:0] r_rdv;

    logic [XW-1:0]      pos_x;
    logic [XW-1:0]      cnt_x;
    logic [CW-1:0]      jm1;
    logic [CW:0]        jp1;
    logic               better;
    logic [AW-1:0]      rd_addr;
    logic [AW-1:0]      wr_addr;
    logic signed [31:0] wr_data;
    logic               wr_en;
    logic [CW-1:0]      ins_pos;

    assign pos_x  = XW'(r_pos);
    assign cnt_x  = XW'(r_cnt);
    assign jm1    = r_j - 1'b1;
    assign jp1    = {1'b0, r_j} + 1'b1;
    assign better = (r_act == A_SORT_DOWN) ? (r_pick_val < r_rd) : (r_rd < r_pick_val);

    always_comb begin
        priority if (r_act == A_INS_FRONT) begin
            ins_pos = '0;
        end else if (r_act == A_INS_BACK || pos_x >= cnt_x) begin
            ins_pos = r_cnt;
        end else begin
            ins_pos = pos_x[CW-1:0];
        end
    end

    always_comb begin
        o_stat.act        = r_act;
        o_stat.empty      = (r_cnt == '0);
        o_stat.full       = (r_cnt == CW'(CAPACITY));
        o_stat.j_eq_i     = (r_j == r_i);
        o_stat.j_eq_cnt   = (r_j == r_cnt);
        o_stat.j1_ge_cnt  = (jp1 >= {1'b0, r_cnt});
        o_stat.i_eq_cnt   = (r_i == r_cnt);
        o_stat.match      = (r_rd == r_val);
        o_stat.pick_ne_i  = (r_pick != r_i);
        o_stat.pos_ge_cnt = (pos_x >= cnt_x);
    end

    always_comb begin
        rd_addr = r_j[AW-1:0];
        wr_en   = 1'b0;
        wr_addr = r_j[AW-1:0];
        wr_data = r_rd;
        unique case (i_cmd.uop)
            U_SHIFT_RD: rd_addr = jm1[AW-1:0];
            U_RM_RD:    rd_addr = jp1[AW-1:0];
            U_SO_RDI:   rd_addr = r_i[AW-1:0];
            U_RD_POS:   rd_addr = pos_x[AW-1:0];
            U_SHIFT_WR, U_RM_WR: begin
                wr_en = 1'b1;
            end
            U_INS_FIN: begin
                wr_en   = 1'b1;
                wr_addr = r_i[AW-1:0];
                wr_data = r_val;
            end
            U_SO_SW1: begin
                wr_en   = 1'b1;
                wr_addr = r_i[AW-1:0];
                wr_data = r_pick_val;
            end
            U_SO_SW2: begin
                wr_en   = 1'b1;
                wr_addr = r_pick[AW-1:0];
                wr_data = r_cur_val;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_rd <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            unique case (i_cmd.uop)
                U_FIN_DEC, U_FIN_CLR: begin
                    r_cnt <= (i_cmd.uop == U_FIN_CLR) ? '0 : r_cnt - 1'b1;
                end
                U_INS_FIN: r_cnt <= r_cnt + 1'b1;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.uop)
            U_LOAD: begin
                r_act <= i_action;
                r_val <= i_value;
                r_pos <= i_position;
            end
            U_FIN: begin
                r_status <= i_cmd.status;
                r_found  <= 1'b0;
                r_rdv    <= '0;
            end
            U_FIN_FOUND: begin
                r_status <= ST_OK;
                r_found  <= 1'b1;
                r_rdv    <= '0;
            end
            U_FIN_READ: begin
                r_status <= ST_OK;
                r_found  <= 1'b0;
                r_rdv    <= r_rd;
            end
            U_FIN_DEC, U_FIN_CLR, U_INS_FIN: begin
                r_status <= ST_OK;
                r_found  <= 1'b0;
                r_rdv    <= '0;
            end
            U_INS_INIT: begin
                r_j <= r_cnt;
                r_i <= ins_pos;
            end
            U_SHIFT_WR: r_j <= jm1;
            U_J_ZERO:   r_j <= '0;
            U_J_INC, U_RM_WR, U_SO_CMP: begin
                r_j <= jp1[CW-1:0];
                if (i_cmd.uop == U_SO_CMP && better) begin
                    r_pick     <= r_j;
                    r_pick_val <= r_rd;
                end
            end
            U_I_ZERO: r_i <= '0;
            U_SO_LDI: begin
                r_cur_val  <= r_rd;
                r_pick_val <= r_rd;
                r_pick     <= r_i;
                r_j        <= r_i + 1'b1;
            end
            U_I_INC, U_SO_SW2: r_i <= r_i + 1'b1;
            default: begin
            end
        endcase
    end

    assign o_status      = r_status;
    assign o_found       = r_found;
    assign o_read_value  = r_rdv;
    assign o_entry_count = cnt_x[6:0];

endmodule

// File: rtl/core/bole_ctrl.sv
// Controller state machine of the ordered list engine.
module bole_ctrl import bole_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  start,
    output logic  busy,
    output logic  o_done,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    `include "bounded_ordered_list_engine_macros.svh"

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DISP   = 4'd1;
    localparam logic [3:0] S_SH_CHK = 4'd2;
    localparam logic [3:0] S_SH_WR  = 4'd3;
    localparam logic [3:0] S_SC_RD  = 4'd4;
    localparam logic [3:0] S_SC_CMP = 4'd5;
    localparam logic [3:0] S_RM_CHK = 4'd6;
    localparam logic [3:0] S_RM_WR  = 4'd7;
    localparam logic [3:0] S_SO_OUT = 4'd8;
    localparam logic [3:0] S_SO_LDI = 4'd9;
    localparam logic [3:0] S_SO_IN  = 4'd10;
    localparam logic [3:0] S_SO_CMP = 4'd11;
    localparam logic [3:0] S_SO_SW1 = 4'd12;
    localparam logic [3:0] S_SO_SW2 = 4'd13;
    localparam logic [3:0] S_RD_FIN = 4'd14;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic       r_done;
    logic       n_done;

    always_comb begin
        n_state       = r_state;
        o_cmd.uop     = U_NOP;
        o_cmd.status  = ST_OK;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.uop = U_LOAD;
                    n_state   = S_DISP;
                end
            end
            S_DISP: begin
                n_state = S_IDLE;
                priority if (i_stat.act == A_INS_FRONT || i_stat.act == A_INS_BACK
                             || i_stat.act == A_INS_AT) begin
                    if (i_stat.full) begin
                        o_cmd.uop    = U_FIN;
                        o_cmd.status = ST_FULL;
                    end else begin
                        o_cmd.uop = U_INS_INIT;
                        n_state   = S_SH_CHK;
                    end
                end else if (i_stat.act > A_READ) begin
                    o_cmd.uop = U_FIN;
                end else if (i_stat.empty) begin
                    o_cmd.uop    = U_FIN;
                    o_cmd.status = ST_EMPTY;
                end else if (i_stat.act == A_DEL_VAL || i_stat.act == A_SEARCH) begin
                    o_cmd.uop = U_J_ZERO;
                    n_state   = S_SC_RD;
                end else if (i_stat.act == A_DEL_FIRST) begin
                    o_cmd.uop = U_J_ZERO;
                    n_state   = S_RM_CHK;
                end else if (i_stat.act == A_DEL_LAST) begin
                    o_cmd.uop = U_FIN_DEC;
                end else if (i_stat.act == A_CLEAR) begin
                    o_cmd.uop = U_FIN_CLR;
                end else if (i_stat.act == A_SORT_UP || i_stat.act == A_SORT_DOWN) begin
                    o_cmd.uop = U_I_ZERO;
                    n_state   = S_SO_OUT;
                end else if (i_stat.pos_ge_cnt) begin
                    o_cmd.uop    = U_FIN;
                    o_cmd.status = ST_RANGE;
                end else begin
                    o_cmd.uop = U_RD_POS;
                    n_state   = S_RD_FIN;
                end
            end
            S_SH_CHK: begin
                if (i_stat.j_eq_i) begin
                    o_cmd.uop = U_INS_FIN;
                    n_state   = S_IDLE;
                end else begin
                    o_cmd.uop = U_SHIFT_RD;
                    n_state   = S_SH_WR;
                end
            end
            S_SH_WR: begin
                o_cmd.uop = U_SHIFT_WR;
                n_state   = S_SH_CHK;
            end
            S_SC_RD: begin
                if (i_stat.j_eq_cnt) begin
                    o_cmd.uop    = U_FIN;
                    o_cmd.status = ST_NOTFOUND;
                    n_state      = S_IDLE;
                end else begin
                    o_cmd.uop = U_SCAN_RD;
                    n_state   = S_SC_CMP;
                end
            end
            S_SC_CMP: begin
                priority if (!i_stat.match) begin
                    o_cmd.uop = U_J_INC;
                    n_state   = S_SC_RD;
                end else if (i_stat.act == A_SEARCH) begin
                    o_cmd.uop = U_FIN_FOUND;
                    n_state   = S_IDLE;
                end else begin
                    n_state = S_RM_CHK;
                end
            end
            S_RM_CHK: begin
                if (i_stat.j1_ge_cnt) begin
                    o_cmd.uop = U_FIN_DEC;
                    n_state   = S_IDLE;
                end else begin
                    o_cmd.uop = U_RM_RD;
                    n_state   = S_RM_WR;
                end
            end
            S_RM_WR: begin
                o_cmd.uop = U_RM_WR;
                n_state   = S_RM_CHK;
            end
            S_SO_OUT: begin
                if (i_stat.i_eq_cnt) begin
                    o_cmd.uop = U_FIN;
                    n_state   = S_IDLE;
                end else begin
                    o_cmd.uop = U_SO_RDI;
                    n_state   = S_SO_LDI;
                end
            end
            S_SO_LDI: begin
                o_cmd.uop = U_SO_LDI;
                n_state   = S_SO_IN;
            end
            S_SO_IN: begin
                if (i_stat.j_eq_cnt) begin
                    n_state = S_SO_SW1;
                end else begin
                    o_cmd.uop = U_SO_RDJ;
                    n_state   = S_SO_CMP;
                end
            end
            S_SO_CMP: begin
                o_cmd.uop = U_SO_CMP;
                n_state   = S_SO_IN;
            end
            S_SO_SW1: begin
                if (i_stat.pick_ne_i) begin
                    o_cmd.uop = U_SO_SW1;
                    n_state   = S_SO_SW2;
                end else begin
                    o_cmd.uop = U_I_INC;
                    n_state   = S_SO_OUT;
                end
            end
            S_SO_SW2: begin
                o_cmd.uop = U_SO_SW2;
                n_state   = S_SO_OUT;
            end
            S_RD_FIN: begin
                o_cmd.uop = U_FIN_READ;
                n_state   = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // A result is shown in the cycle after the last work cycle.
    assign n_done = (r_state != S_IDLE) && (n_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    assign busy   = (r_state != S_IDLE);
    assign o_done = r_done;

    `BOLE_ASSERT_SAME(a_done_not_busy, o_done, !busy, "result strobe while busy")
    `BOLE_ASSERT_NEXT(a_start_busy, start && !busy, busy, "accepted transaction did not start")
    `BOLE_ASSERT_SAME(a_fell_done, $fell(busy), o_done, "transaction ended without a result")

endmodule

// File: rtl/core/bounded_ordered_list_engine.sv
// Ordered list engine: one result per transaction, shown for one cycle on o_done; the
// receiver cannot stall it. A transaction is taken when start is high and busy is low.
// All work goes through one entry memory with one write port and a registered read
// port, so each entry moved or compared takes a read step and then a write or compare
// step. With n entries held, a sort makes at most n-1 swaps. Delete last, clear, insert
// into a full list, a read out of range, unused action codes and empty-list operations
// finish in the dispatch state without touching the entry memory.
// busy drops in the cycle that shows the result, so the next transaction can be taken
// in that same cycle.
module bounded_ordered_list_engine import bole_pkg::*; #(
    parameter int CAPACITY = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [3:0]         i_action,
    input  logic signed [31:0] i_value,
    input  logic [6:0]         i_position,
    output logic               o_done,
    output logic [2:0]         o_status,
    output logic               o_found,
    output logic signed [31:0] o_read_value,
    output logic [6:0]         o_entry_count
);

    t_cmd  cmd;
    t_stat stat;

    bole_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_done  (o_done),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    bole_dpath #(
        .CAPACITY (CAPACITY)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_action      (i_action),
        .i_value       (i_value),
        .i_position    (i_position),
        .o_stat        (stat),
        .o_status      (o_status),
        .o_found       (o_found),
        .o_read_value  (o_read_value),
        .o_entry_count (o_entry_count)
    );

endmodule

// File: bench/bounded_ordered_list_engine_tb.sv
// Self-checking testbench of the ordered list engine with a scoreboard and a predictor.
`timescale 1ns / 100ps

module bounded_ordered_list_engine_tb;
    import bole_pkg::*;

    localparam int          CAP          = 64;
    localparam int          CYCLE_LIMIT  = 3000000;
    localparam int          RANDOM_ITEMS = 600;
    localparam logic [3:0]  A_SPARE_LO   = 4'd11;
    localparam logic [3:0]  A_SPARE_HI   = 4'd15;

    typedef struct {
        logic [2:0]  status;
        logic        found;
        logic [31:0] rd;
        logic [6:0]  cnt;
    } t_list_outcome;

    class t_list_scoreboard;
        logic signed [31:0] entries [CAP];
        int                 count;
        t_list_outcome      awaited [$];
        int                 errors;
        int                 checked;

        function new();
            count = 0;
            errors = 0;
            checked = 0;
        endfunction

        function int find_first(logic signed [31:0] v);
            for (int k = 0; k < count; k++) begin
                if (entries[k] == v) return k;
            end
            return count;
        endfunction

        function void remove_at(int pos);
            for (int k = pos; k + 1 < count; k++) entries[k] = entries[k + 1];
            count--;
        endfunction

        function logic [2:0] insert_at(int pos, logic signed [31:0] v);
            if (count >= CAP) return ST_FULL;
            if (pos > count) pos = count;
            for (int k = count; k > pos; k--) entries[k] = entries[k - 1];
            entries[pos] = v;
            count++;
            return ST_OK;
        endfunction

        function void selection_sort(bit descending);
            int                 pick;
            logic signed [31:0] t;
            for (int i = 0; i < count; i++) begin
                pick = i;
                for (int j = i + 1; j < count; j++) begin
                    if (descending ? (entries[pick] < entries[j])
                                   : (entries[j] < entries[pick])) pick = j;
                end
                t = entries[i];
                entries[i] = entries[pick];
                entries[pick] = t;
            end
        endfunction

        // Apply one accepted transaction to the shadow list and queue its outcome.
        function void note_command(logic [3:0] act, logic signed [31:0] v, logic [6:0] pos);
            t_list_outcome o;
            int            k;
            o.status = ST_OK;
            o.found = 1'b0;
            o.rd = '0;
            case (act)
                A_INS_FRONT: o.status = insert_at(0, v);
                A_INS_BACK:  o.status = insert_at(count, v);
                A_INS_AT:    o.status = insert_at(int'(pos), v);
                A_DEL_VAL: begin
                    if (count == 0) o.status = ST_EMPTY;
                    else begin
                        k = find_first(v);
                        if (k >= count) o.status = ST_NOTFOUND;
                        else remove_at(k);
                    end
                end
                A_DEL_FIRST: begin
                    if (count == 0) o.status = ST_EMPTY;
                    else remove_at(0);
                end
                A_DEL_LAST: begin
                    if (count == 0) o.status = ST_EMPTY;
                    else count--;
                end
                A_CLEAR: begin
                    if (count == 0) o.status = ST_EMPTY;
                    else count = 0;
                end
                A_SEARCH: begin
                    if (count == 0) o.status = ST_EMPTY;
                    else if (find_first(v) < count) o.found = 1'b1;
                    else o.status = ST_NOTFOUND;
                end
                A_SORT_UP, A_SORT_DOWN: begin
                    if (count == 0) o.status = ST_EMPTY;
                    else selection_sort(act == A_SORT_DOWN);
                end
                A_READ: begin
                    if (count == 0) o.status = ST_EMPTY;
                    else if (int'(pos) >= count) o.status = ST_RANGE;
                    else o.rd = entries[pos];
                end
                default: ;
            endcase
            o.cnt = 7'(count);
            awaited.push_back(o);
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            errors++;
            $display("mismatch: %s got 0x%0h expected 0x%0h", what, got, want);
        endtask

        task check_result(logic [2:0] st, logic fnd, logic [31:0] rd, logic [6:0] cnt);
            t_list_outcome o;
            checked++;
            if (awaited.size() == 0) begin
                report("result with no transaction pending, status", 32'(st), 32'(0));
                return;
            end
            o = awaited.pop_front();
            if (st !== o.status) report("status", 32'(st), 32'(o.status));
            if (fnd !== o.found) report("found", 32'(fnd), 32'(o.found));
            if (rd !== o.rd) report("read_value", rd, o.rd);
            if (cnt !== o.cnt) report("entry_count", 32'(cnt), 32'(o.cnt));
        endtask

        function int pending();
            return awaited.size();
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [3:0]         i_action = '0;
    logic signed [31:0] i_value = '0;
    logic [6:0]         i_position = '0;
    logic               o_done;
    logic [2:0]         o_status;
    logic               o_found;
    logic signed [31:0] o_read_value;
    logic [6:0]         o_entry_count;

    t_list_scoreboard sb = new();
    int               cycles = 0;
    int               sorts_done = 0;
    int               fulls_hit = 0;

    bounded_ordered_list_engine #(.CAPACITY(CAP)) u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_action(i_action), .i_value(i_value), .i_position(i_position),
        .o_done(o_done), .o_status(o_status), .o_found(o_found),
        .o_read_value(o_read_value), .o_entry_count(o_entry_count)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) sb.check_result(o_status, o_found, o_read_value, o_entry_count);
    end

    // Leaves start high on return, so a following transaction can go out back to back.
    task automatic send_cmd(logic [3:0] act, logic signed [31:0] v, logic [6:0] pos);
        start <= 1'b1;
        i_action <= act;
        i_value <= v;
        i_position <= pos;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        sb.note_command(act, v, pos);
        if (act == A_SORT_UP || act == A_SORT_DOWN) sorts_done++;
        if (sb.awaited[$].status == ST_FULL) fulls_hit++;
    endtask

    task automatic idle_cycles(int n);
        if (n > 0) begin
            start <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic random_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) idle_cycles(0);
        else if (r < 90) idle_cycles($urandom_range(1, 3));
        else idle_cycles($urandom_range(10, 60));
    endtask

    function automatic logic signed [31:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return 32'sh8000_0000;
        if (r < 20) return 32'sh7fff_ffff;
        if (r < 65) return $signed(32'($urandom_range(0, 12)) - 32'd6);
        return $signed($urandom());
    endfunction

    // Mostly well-formed traffic; insert and delete weights keep the fill level moving.
    task automatic random_cmd(int bias);
        logic [3:0] act;
        int         r;
        r = $urandom_range(0, 99);
        if (r < bias) act = 4'($urandom_range(int'(A_INS_FRONT), int'(A_INS_AT)));
        else if (r < 70) act = 4'($urandom_range(int'(A_DEL_VAL), int'(A_DEL_LAST)));
        else if (r < 72) act = A_CLEAR;
        else if (r < 82) act = A_SEARCH;
        else if (r < 86) act = ($urandom_range(0, 1) != 0) ? A_SORT_UP : A_SORT_DOWN;
        else if (r < 98) act = A_READ;
        else act = 4'($urandom_range(int'(A_SPARE_LO), int'(A_SPARE_HI)));
        send_cmd(act, pick_value(),
                 ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 127))
                                             : 7'($urandom_range(0, sb.count)));
    endtask

    initial begin
        int bias;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // Directed: every non-insert operation on an empty list, then spare codes.
        for (int a = int'(A_DEL_VAL); a <= int'(A_READ); a++) send_cmd(4'(a), '0, '0);
        send_cmd(A_SPARE_LO, '0, '0);
        send_cmd(A_SPARE_HI, -1, 7'd127);
        send_cmd(A_INS_BACK, 32'sh8000_0000, '0);
        send_cmd(A_INS_FRONT, 32'sh7fff_ffff, '0);
        send_cmd(A_INS_AT, -1, 7'd127);
        send_cmd(A_INS_AT, 32'sd0, 7'd1);
        send_cmd(A_SEARCH, -1, '0);
        send_cmd(A_SEARCH, 32'sd77, '0);
        send_cmd(A_DEL_VAL, 32'sd77, '0);
        send_cmd(A_SORT_UP, '0, '0);
        send_cmd(A_READ, '0, 7'd3);
        send_cmd(A_READ, '0, 7'd4);
        send_cmd(A_SORT_DOWN, '0, '0);
        send_cmd(A_READ, '0, 7'd0);
        send_cmd(A_DEL_VAL, 32'sd0, '0);
        send_cmd(A_DEL_FIRST, '0, '0);
        send_cmd(A_DEL_LAST, '0, '0);
        idle_cycles(1);

        // Fill to capacity, push on the full list, then read, sort and clear it.
        while (sb.count < CAP) send_cmd(A_INS_BACK, $signed($urandom()), '0);
        send_cmd(A_INS_FRONT, 32'sd1, '0);
        send_cmd(A_INS_AT, 32'sd2, 7'd64);
        send_cmd(A_READ, '0, 7'd63);
        send_cmd(A_READ, '0, 7'd64);
        send_cmd(A_SORT_DOWN, '0, '0);
        send_cmd(A_CLEAR, '0, '0);

        // Hold the sender off until the engine has drained.
        idle_cycles(1);
        while (sb.pending() != 0) @(posedge i_clk);

        bias = 45;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 100 == 0) bias = $urandom_range(25, 60);
            if (sb.count < 4) random_cmd(bias + 20);
            else random_cmd(bias);
            if (n % 150 < 30) idle_cycles(0);
            else random_gap();
        end
        idle_cycles(1);

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("ran %0d transactions: %0d sorts, %0d refused on a full list",
                 sb.checked, sorts_done, fulls_hit);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("%0d mismatches, %0d results missing", sb.errors, sb.pending());
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/bole_pkg.sv
rtl/core/bole_dpath.sv
rtl/core/bole_ctrl.sv
rtl/core/bounded_ordered_list_engine.sv
bench/bounded_ordered_list_engine_tb.sv
